// ===== design/lpba_pkg.sv =====
`default_nettype none
package lpba_pkg;

  localparam int MAX_BOXES = 16;
  // Slot field is four bits wide, so no more than sixteen slots are addressable
  localparam int NUM_CELLS = (MAX_BOXES < 16) ? MAX_BOXES : 16;

  localparam int SUM_W     = 58;   // exact width of a projected row sum
  localparam int QUOT_W    = 17;   // quotient bits before saturation
  localparam int DSH_W     = SUM_W + QUOT_W - 1;
  localparam int DIV_STEPS = QUOT_W;

  localparam logic [15:0] SHRINK_RESET = 16'd6554;

  typedef enum logic [1:0] {
    OP_CLEAR    = 2'd0,
    OP_LOAD     = 2'd1,
    OP_CLASSIFY = 2'd2,
    OP_NOP      = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_NONE   = 2'd0,
    ST_ONE    = 2'd1,
    ST_MANY   = 2'd2,
    ST_NONPOS = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    CFG_ROW0_XY = 3'd0,
    CFG_ROW0_ZT = 3'd1,
    CFG_ROW1_XY = 3'd2,
    CFG_ROW1_ZT = 3'd3,
    CFG_ROW2_XY = 3'd4,
    CFG_ROW2_ZT = 3'd5,
    CFG_SHRINK  = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    op_e                op;
    logic [3:0]         slot;
    logic signed [12:0] left;
    logic signed [12:0] top;
    logic [11:0]        width;
    logic [11:0]        height;
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic signed [23:0] z;
  } in_t;

  typedef struct packed {
    logic signed [13:0] left;
    logic signed [13:0] top;
    logic [11:0]        width;
    logic [11:0]        height;
  } box_t;

  typedef struct packed {
    op_e        op;
    logic [3:0] slot;
    box_t       box;
  } side_t;

  typedef struct packed {
    side_t             side;
    logic              nonpos;
    logic              neg_u;
    logic              neg_v;
    logic              ovf_u;
    logic              ovf_v;
    logic [SUM_W-1:0]  rem_u;
    logic [SUM_W-1:0]  rem_v;
    logic [DSH_W-1:0]  dsh;
    logic [QUOT_W-1:0] q_u;
    logic [QUOT_W-1:0] q_v;
  } div_t;

  typedef struct packed {
    side_t              side;
    logic               nonpos;
    logic signed [15:0] u;
    logic signed [15:0] v;
    logic [1:0]         cnt;
    logic [3:0]         found;
  } tok_t;

endpackage
`default_nettype wire

// ===== design/lpba_proj.sv =====
`default_nettype none
module lpba_proj (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                en_i,
  input  wire logic                valid_i,
  input  wire lpba_pkg::in_t       in_i,
  input  wire logic [5:0][63:0]    coef_i,
  input  wire logic [15:0]         shrink_i,
  output logic                     valid_o,
  output lpba_pkg::div_t           stage_o
);
  import lpba_pkg::*;

  // stage 1: products
  logic signed [55:0] p_d [3][3];
  logic signed [55:0] p_q [3][3];
  logic signed [31:0] ct_d [3];
  logic signed [31:0] ct_q [3];
  logic [27:0]        sfw_d, sfh_d, sfw_q, sfh_q;
  logic [28:0]        kw_d, kh_d, kw_q, kh_q;
  logic [16:0]        keep;
  in_t                in1_q;
  logic               v1_q;

  // stage 2: sums and shrunk box
  logic signed [SUM_W-1:0] s_d [3];
  logic signed [SUM_W-1:0] s_q [3];
  logic signed [30:0]      tl, tt, tlb, ttb;
  side_t                   side2_d, side2_q;
  logic                    v2_q;

  // stage 3: magnitudes and range checks
  div_t                    st_d;
  logic [SUM_W-1:0]        mag_u, mag_v;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      p_d[r][0] = $signed(coef_i[2*r][63:32]) * in_i.x;
      p_d[r][1] = $signed(coef_i[2*r][31:0]) * in_i.y;
      p_d[r][2] = $signed(coef_i[2*r+1][63:32]) * in_i.z;
      ct_d[r]   = $signed(coef_i[2*r+1][31:0]);
    end
    keep  = 17'h10000 - {1'b0, shrink_i};
    sfw_d = shrink_i * in_i.width;
    sfh_d = shrink_i * in_i.height;
    kw_d  = keep * in_i.width;
    kh_d  = keep * in_i.height;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q   <= p_d;
      ct_q  <= ct_d;
      sfw_q <= sfw_d;
      sfh_q <= sfh_d;
      kw_q  <= kw_d;
      kh_q  <= kh_d;
      in1_q <= in_i;
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      s_d[r] = SUM_W'(p_q[r][0]) + SUM_W'(p_q[r][1]) + SUM_W'(p_q[r][2])
             + (SUM_W'(ct_q[r]) <<< 10);
    end
    // truncate toward zero: bias negatives before the arithmetic shift
    tl  = (31'(in1_q.left) <<< 17) + $signed({3'b000, sfw_q});
    tt  = (31'(in1_q.top) <<< 17) + $signed({3'b000, sfh_q});
    tlb = tl + (tl[30] ? 31'sd131071 : 31'sd0);
    ttb = tt + (tt[30] ? 31'sd131071 : 31'sd0);
    side2_d.op         = in1_q.op;
    side2_d.slot       = in1_q.slot;
    side2_d.box.left   = tlb[30:17];
    side2_d.box.top    = ttb[30:17];
    side2_d.box.width  = kw_q[27:16];
    side2_d.box.height = kh_q[27:16];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s_q     <= s_d;
      side2_q <= side2_d;
    end
  end

  always_comb begin
    mag_u        = s_q[0][SUM_W-1] ? SUM_W'(-s_q[0]) : SUM_W'(s_q[0]);
    mag_v        = s_q[1][SUM_W-1] ? SUM_W'(-s_q[1]) : SUM_W'(s_q[1]);
    st_d.side    = side2_q;
    st_d.nonpos  = s_q[2][SUM_W-1] || (s_q[2] == '0);
    st_d.neg_u   = s_q[0][SUM_W-1];
    st_d.neg_v   = s_q[1][SUM_W-1];
    // quotient would need more than QUOT_W bits: saturate
    st_d.ovf_u   = {{QUOT_W{1'b0}}, mag_u} >= {s_q[2], {QUOT_W{1'b0}}};
    st_d.ovf_v   = {{QUOT_W{1'b0}}, mag_v} >= {s_q[2], {QUOT_W{1'b0}}};
    st_d.rem_u   = mag_u;
    st_d.rem_v   = mag_v;
    st_d.dsh     = {s_q[2], {(QUOT_W-1){1'b0}}};
    st_d.q_u     = '0;
    st_d.q_v     = '0;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stage_o <= st_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      valid_o <= 1'b0;
    end else if (en_i) begin
      v1_q    <= valid_i;
      v2_q    <= v1_q;
      valid_o <= v2_q;
    end
  end

endmodule
`default_nettype wire

// ===== design/lpba_div_step.sv =====
`default_nettype none
module lpba_div_step (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           en_i,
  input  wire logic           valid_i,
  input  wire lpba_pkg::div_t stage_i,
  output logic                valid_o,
  output lpba_pkg::div_t      stage_o
);
  import lpba_pkg::*;

  div_t stage_d;
  logic ge_u, ge_v;

  // one restoring step per lane against the shared shifted divisor
  always_comb begin
    stage_d = stage_i;
    ge_u    = {{(DSH_W-SUM_W){1'b0}}, stage_i.rem_u} >= stage_i.dsh;
    ge_v    = {{(DSH_W-SUM_W){1'b0}}, stage_i.rem_v} >= stage_i.dsh;
    if (ge_u) begin
      stage_d.rem_u = stage_i.rem_u - stage_i.dsh[SUM_W-1:0];
    end
    if (ge_v) begin
      stage_d.rem_v = stage_i.rem_v - stage_i.dsh[SUM_W-1:0];
    end
    stage_d.q_u = {stage_i.q_u[QUOT_W-2:0], ge_u};
    stage_d.q_v = {stage_i.q_v[QUOT_W-2:0], ge_v};
    stage_d.dsh = stage_i.dsh >> 1;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stage_o <= stage_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

endmodule
`default_nettype wire

// ===== design/lpba_cell.sv =====
`default_nettype none
module lpba_cell (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           en_i,
  input  wire logic [3:0]     cell_idx_i,
  input  wire logic           valid_i,
  input  wire lpba_pkg::tok_t tok_i,
  output logic                valid_o,
  output lpba_pkg::tok_t      tok_o
);
  import lpba_pkg::*;

  box_t               box_q;
  logic               bvalid_q;
  logic signed [16:0] lo_u, hi_u, lo_v, hi_v, u17, v17;
  logic               hit;
  tok_t               tok_d;

  always_comb begin
    u17   = 17'(tok_i.u);
    v17   = 17'(tok_i.v);
    lo_u  = 17'(box_q.left);
    lo_v  = 17'(box_q.top);
    hi_u  = lo_u + $signed({5'b0, box_q.width});
    hi_v  = lo_v + $signed({5'b0, box_q.height});
    hit   = bvalid_q && (u17 >= lo_u) && (u17 < hi_u) && (v17 >= lo_v) && (v17 < hi_v);
    tok_d = tok_i;
    if (valid_i && (tok_i.side.op == OP_CLASSIFY) && !tok_i.nonpos && hit) begin
      case (tok_i.cnt)
        2'd0: begin
          tok_d.cnt   = 2'd1;
          tok_d.found = cell_idx_i;
        end
        2'd1: tok_d.cnt = 2'd2;
        default: tok_d.cnt = tok_i.cnt;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tok_o <= tok_d;
      if (valid_i && (tok_i.side.op == OP_LOAD) && (tok_i.side.slot == cell_idx_i)) begin
        box_q <= tok_i.side.box;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o  <= 1'b0;
      bvalid_q <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
      if (valid_i && (tok_i.side.op == OP_CLEAR)) begin
        bvalid_q <= 1'b0;
      end else if (valid_i && (tok_i.side.op == OP_LOAD) &&
                   (tok_i.side.slot == cell_idx_i)) begin
        bvalid_q <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== design/lidar_point_box_association_top.sv =====
// Pipeline: a classify beat passes the input register, 3 projection stages,
// 17 divider steps, the saturation register, one register per box cell
// and the output register before it shows on the output.
// Throughput: one beat per cycle; the whole pipeline holds while a result waits.
// Reset: asynchronous, active low; clears all box valid bits, pipeline valids,
// and loads default configuration (coefficients zero, shrink 6554).
`default_nettype none
module lidar_point_box_association_top (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [2:0]         cfg_idx_i,
  input  wire logic [63:0]        cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [1:0]         opcode_i,
  input  wire logic [3:0]         slot_i,
  input  wire logic signed [12:0] box_left_i,
  input  wire logic signed [12:0] box_top_i,
  input  wire logic [11:0]        box_width_i,
  input  wire logic [11:0]        box_height_i,
  input  wire logic signed [23:0] point_x_i,
  input  wire logic signed [23:0] point_y_i,
  input  wire logic signed [23:0] point_z_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [1:0]              status_o,
  output logic [3:0]              box_slot_o,
  output logic signed [15:0]      pixel_u_o,
  output logic signed [15:0]      pixel_v_o
);
  import lpba_pkg::*;

  logic [5:0][63:0] coef_q;
  logic [15:0]      shrink_q;

  logic             en;
  logic             s0_ld;
  logic             s0_valid_q;
  in_t              s0_q;

  div_t             dv [DIV_STEPS+1];
  logic             dv_valid [DIV_STEPS+1];
  tok_t             tk [NUM_CELLS+1];
  logic             tk_valid [NUM_CELLS+1];
  tok_t             tk0_d;

  logic             out_valid_q;
  logic [1:0]       status_q, status_d;
  logic [3:0]       slot_q, slot_d;
  logic signed [15:0] u_q, v_q, u_d, v_d;

  function automatic logic signed [15:0] sat_q(input logic neg, input logic ovf,
                                               input logic [QUOT_W-1:0] q);
    logic signed [15:0] r;
    if (neg) begin
      r = (ovf || (q > QUOT_W'(32768))) ? -16'sd32768 : -$signed(16'(q));
    end else begin
      r = (ovf || (q > QUOT_W'(32767))) ? 16'sd32767 : $signed(16'(q));
    end
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q   <= '0;
      shrink_q <= SHRINK_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_ROW0_XY: coef_q[0] <= cfg_data_i;
        CFG_ROW0_ZT: coef_q[1] <= cfg_data_i;
        CFG_ROW1_XY: coef_q[2] <= cfg_data_i;
        CFG_ROW1_ZT: coef_q[3] <= cfg_data_i;
        CFG_ROW2_XY: coef_q[4] <= cfg_data_i;
        CFG_ROW2_ZT: coef_q[5] <= cfg_data_i;
        CFG_SHRINK:  shrink_q  <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // advance the pipeline whenever the output register is free or draining
  assign en         = !out_valid_q || out_ready_i;
  assign s0_ld      = !s0_valid_q || en;
  assign in_ready_o = s0_ld;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (s0_ld) begin
      // drop the unused opcode at the door
      s0_valid_q <= in_valid_i && (opcode_i != OP_NOP);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s0_ld && in_valid_i) begin
      s0_q.op     <= op_e'(opcode_i);
      s0_q.slot   <= slot_i;
      s0_q.left   <= box_left_i;
      s0_q.top    <= box_top_i;
      s0_q.width  <= box_width_i;
      s0_q.height <= box_height_i;
      s0_q.x      <= point_x_i;
      s0_q.y      <= point_y_i;
      s0_q.z      <= point_z_i;
    end
  end

  lpba_proj u_proj (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (s0_valid_q),
    .in_i     (s0_q),
    .coef_i   (coef_q),
    .shrink_i (shrink_q),
    .valid_o  (dv_valid[0]),
    .stage_o  (dv[0])
  );

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    lpba_div_step u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (dv_valid[k]),
      .stage_i (dv[k]),
      .valid_o (dv_valid[k+1]),
      .stage_o (dv[k+1])
    );
  end

  always_comb begin
    tk0_d.side   = dv[DIV_STEPS].side;
    tk0_d.nonpos = dv[DIV_STEPS].nonpos;
    tk0_d.u      = sat_q(dv[DIV_STEPS].neg_u, dv[DIV_STEPS].ovf_u, dv[DIV_STEPS].q_u);
    tk0_d.v      = sat_q(dv[DIV_STEPS].neg_v, dv[DIV_STEPS].ovf_v, dv[DIV_STEPS].q_v);
    tk0_d.cnt    = 2'd0;
    tk0_d.found  = 4'd0;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      tk[0] <= tk0_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tk_valid[0] <= 1'b0;
    end else if (en) begin
      tk_valid[0] <= dv_valid[DIV_STEPS];
    end
  end

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    lpba_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .en_i       (en),
      .cell_idx_i (4'(i)),
      .valid_i    (tk_valid[i]),
      .tok_i      (tk[i]),
      .valid_o    (tk_valid[i+1]),
      .tok_o      (tk[i+1])
    );
  end

  always_comb begin
    slot_d = 4'd0;
    u_d    = tk[NUM_CELLS].u;
    v_d    = tk[NUM_CELLS].v;
    case (tk[NUM_CELLS].cnt)
      2'd0: status_d = ST_NONE;
      2'd1: begin
        status_d = ST_ONE;
        slot_d   = tk[NUM_CELLS].found;
      end
      default: status_d = ST_MANY;
    endcase
    if (tk[NUM_CELLS].nonpos) begin
      status_d = ST_NONPOS;
      slot_d   = 4'd0;
      u_d      = '0;
      v_d      = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= tk_valid[NUM_CELLS] && (tk[NUM_CELLS].side.op == OP_CLASSIFY);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      status_q <= status_d;
      slot_q   <= slot_d;
      u_q      <= u_d;
      v_q      <= v_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign box_slot_o  = slot_q;
  assign pixel_u_o   = u_q;
  assign pixel_v_o   = v_q;

  a_nonpos_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_NONPOS) |->
      (box_slot_o == 4'd0) && (pixel_u_o == 16'sd0) && (pixel_v_o == 16'sd0))
    else $error("non-positive depth result carries data");

  a_slot_only_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_ONE) |-> (box_slot_o == 4'd0))
    else $error("box slot set without a single match");

  a_input_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s0_valid_q && !en |=> s0_valid_q)
    else $error("input register lost a beat while stalled");

  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> s0_valid_q && out_valid_q && !out_ready_i)
    else $error("input back-pressure without a full pipeline");

endmodule
`default_nettype wire
